>>> hdl/keyed_slot_tracker_table_defines.svh
// Assertion macros for the keyed slot tracker table.
`ifndef KEYED_SLOT_TRACKER_TABLE_DEFINES_SVH
`define KEYED_SLOT_TRACKER_TABLE_DEFINES_SVH
`ifndef SYNTH
`define KSTT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KSTT_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define KSTT_ASSERT(name, prop, msg)
`define KSTT_ASSERT_NEVER(name, cond, msg)
`endif
`endif

>>> hdl/kstt_pkg.sv
// Types and constants shared by the slot tracker table modules.
package kstt_pkg;

  localparam int KEY_W    = 32;
  localparam int KIND_W   = 3;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RESOLVE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY    = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BADKIND  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [KIND_W-1:0] kind;
    logic              heading;
  } entry_t;

  typedef struct packed {
    logic key_hit;
    logic class_hit;
    logic free;
  } match_t;

endpackage

>>> hdl/kstt_if.sv
// Valid/ready channel interfaces for request and result items.
interface kstt_in_if;
  logic                          valid;
  logic                          ready;
  logic [kstt_pkg::REQ_W-1:0]    req_type;
  logic [kstt_pkg::KEY_W-1:0]    unit_key;
  logic [kstt_pkg::KIND_W-1:0]   kind;
  logic                          heading;

  modport source (output valid, req_type, unit_key, kind, heading, input ready);
  modport sink   (input valid, req_type, unit_key, kind, heading, output ready);
endinterface

interface kstt_out_if;
  logic                            valid;
  logic                            ready;
  logic [kstt_pkg::STATUS_W-1:0]   status;
  logic [kstt_pkg::COUNT_W-1:0]    live_count;

  modport source (output valid, status, live_count, input ready);
  modport sink   (input valid, status, live_count, output ready);
endinterface

>>> hdl/kstt_store.sv
// Slot entry memory: one write port, one registered read port.
module kstt_store #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IW-1:0]       waddr,
  input  kstt_pkg::entry_t    wdata,
  input  logic                re,
  input  logic [IW-1:0]       raddr,
  output kstt_pkg::entry_t    rdata
);

  kstt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/kstt_cmp.sv
// Shared compare unit: checks one slot against the current request.
module kstt_cmp (
  input  kstt_pkg::entry_t             entry,
  input  logic                         live,
  input  logic [kstt_pkg::KEY_W-1:0]   key,
  input  logic [kstt_pkg::KIND_W-1:0]  kind,
  input  logic                         heading,
  output kstt_pkg::match_t             match
);

  always_comb begin
    match.free      = !live;
    match.key_hit   = live && (entry.key == key);
    match.class_hit = live && (entry.kind == kind) && (entry.heading == heading);
  end

endmodule

>>> hdl/keyed_slot_tracker_table.sv
// Keyed slot tracker table: top level with scan sequencer and valid bits.
//
// Request items arrive on in_ch (req_type, unit_key, kind, heading); one
// result item (status, live_count) leaves on out_ch for each request.
// A request is taken only while the sequencer is idle. It then scans all
// SLOTS entries through the single read port of the entry memory, one slot
// per cycle, feeding the shared compare unit. The scan finds a live entry
// with the key, the lowest free slot, and counts live entries of the
// request's kind and heading. A drain step and a finish step follow,
// where the table is updated and the result is loaded. The next request
// is accepted while a result still waits in the output register; if the
// receiver stalls, the finish step waits until the output register is
// free, and the table is updated only when the result loads.
// Reset clears the valid bits at once, so the table is empty right after
// reset with no clearing pass; key, kind and heading storage is not reset.
// live_count is the count after the operation, saturated at 63, and is 0
// for a kind of KIND_COUNT or more.
`include "keyed_slot_tracker_table_defines.svh"

module keyed_slot_tracker_table #(
  parameter int SLOTS      = 32,
  parameter int KIND_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  kstt_in_if.sink     in_ch,
  kstt_out_if.source  out_ch
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // count width holds SLOTS + 1
  localparam int CW = $clog2(SLOTS + 2);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  kstt_pkg::state_t state_r, state_nxt;

  // captured request
  logic [kstt_pkg::REQ_W-1:0]  req_type_r, req_type_nxt;
  logic [kstt_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [kstt_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic                        heading_r, heading_nxt;

  // scan pointers
  logic [IW-1:0] addr_r, addr_nxt;
  logic [IW-1:0] idx_d_r, idx_d_nxt;
  logic          pend_r, pend_nxt;

  // scan findings
  logic          found_r, found_nxt;
  logic [IW-1:0] found_idx_r, found_idx_nxt;
  logic          found_cls_r, found_cls_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [SLOTS-1:0] valid_r, valid_nxt;

  // output register
  logic                           out_valid_r, out_valid_nxt;
  logic [kstt_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [kstt_pkg::COUNT_W-1:0]   out_count_r, out_count_nxt;

  // memory ports
  logic             mem_we;
  logic             mem_re;
  kstt_pkg::entry_t mem_wdata;
  kstt_pkg::entry_t mem_rdata;
  kstt_pkg::match_t match;

  // finish step
  logic                          kind_ok;
  logic                          out_free;
  logic                          finish_fire;
  logic                          clear_fire;
  logic [kstt_pkg::STATUS_W-1:0] fin_status;
  logic [CW-1:0]                 fin_count;
  logic [15:0]                   fin_count_wide;
  logic [kstt_pkg::COUNT_W-1:0]  fin_live;

  kstt_store #(
    .DEPTH (SLOTS),
    .IW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (free_idx_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  kstt_cmp u_cmp (
    .entry   (mem_rdata),
    .live    (valid_r[idx_d_r]),
    .key     (key_r),
    .kind    (kind_r),
    .heading (heading_r),
    .match   (match)
  );

  assign kind_ok  = {1'b0, kind_r} < 4'(KIND_COUNT);
  assign out_free = !out_valid_r || out_ch.ready;
  assign finish_fire = (state_r == kstt_pkg::S_FINISH) && out_free;
  assign clear_fire  = finish_fire && (req_type_r == kstt_pkg::REQ_CLEAR);

  assign mem_wdata.key     = key_r;
  assign mem_wdata.kind    = kind_r;
  assign mem_wdata.heading = heading_r;

  // decision at the end of the scan
  always_comb begin
    fin_status = kstt_pkg::STAT_OK;
    fin_count  = count_r;
    mem_we     = 1'b0;
    valid_nxt  = valid_r;
    case (req_type_r)
      kstt_pkg::REQ_REGISTER: begin
        if (!kind_ok) begin
          fin_status = kstt_pkg::STAT_BADKIND;
        end else if (found_r) begin
          fin_status = kstt_pkg::STAT_DUP;
        end else if (!free_found_r) begin
          fin_status = kstt_pkg::STAT_FULL;
        end else begin
          fin_count = count_r + CW'(1);
          mem_we    = finish_fire;
          if (finish_fire) begin
            valid_nxt[free_idx_r] = 1'b1;
          end
        end
      end
      kstt_pkg::REQ_RESOLVE: begin
        if (!found_r) begin
          fin_status = kstt_pkg::STAT_NOTFOUND;
        end else begin
          fin_count = count_r - CW'(found_cls_r);
          if (finish_fire) begin
            valid_nxt[found_idx_r] = 1'b0;
          end
        end
      end
      kstt_pkg::REQ_CLEAR: begin
        fin_count = '0;
        if (finish_fire) begin
          valid_nxt = '0;
        end
      end
      default: begin
        // count query
        if (!kind_ok) begin
          fin_status = kstt_pkg::STAT_BADKIND;
        end
      end
    endcase
    fin_count_wide = 16'(fin_count);
    if (!kind_ok) begin
      fin_live = '0;
    end else if (fin_count_wide > 16'(kstt_pkg::COUNT_MAX)) begin
      fin_live = kstt_pkg::COUNT_MAX;
    end else begin
      fin_live = kstt_pkg::COUNT_W'(fin_count_wide);
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    req_type_nxt   = req_type_r;
    key_nxt        = key_r;
    kind_nxt       = kind_r;
    heading_nxt    = heading_r;
    addr_nxt       = addr_r;
    idx_d_nxt      = idx_d_r;
    pend_nxt       = 1'b0;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    found_cls_nxt  = found_cls_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_re         = 1'b0;
    in_ch.ready    = 1'b0;

    // compare stage, one slot behind the read address
    if (pend_r) begin
      if (match.key_hit && !found_r) begin
        found_nxt     = 1'b1;
        found_idx_nxt = idx_d_r;
        found_cls_nxt = match.class_hit;
      end
      if (match.free && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = idx_d_r;
      end
      if (match.class_hit) begin
        count_nxt = count_r + CW'(1);
      end
    end

    case (state_r)
      kstt_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          req_type_nxt   = in_ch.req_type;
          key_nxt        = in_ch.unit_key;
          kind_nxt       = in_ch.kind;
          heading_nxt    = in_ch.heading;
          addr_nxt       = '0;
          found_nxt      = 1'b0;
          found_cls_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          count_nxt      = '0;
          state_nxt      = kstt_pkg::S_SCAN;
        end
      end
      kstt_pkg::S_SCAN: begin
        mem_re    = 1'b1;
        pend_nxt  = 1'b1;
        idx_d_nxt = addr_r;
        if (addr_r == LAST_IDX) begin
          state_nxt = kstt_pkg::S_DRAIN;
        end else begin
          addr_nxt = addr_r + IW'(1);
        end
      end
      kstt_pkg::S_DRAIN: begin
        state_nxt = kstt_pkg::S_FINISH;
      end
      kstt_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status;
          out_count_nxt  = fin_live;
          state_nxt      = kstt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kstt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kstt_pkg::S_IDLE;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r   <= req_type_nxt;
    key_r        <= key_nxt;
    kind_r       <= kind_nxt;
    heading_r    <= heading_nxt;
    addr_r       <= addr_nxt;
    idx_d_r      <= idx_d_nxt;
    found_r      <= found_nxt;
    found_idx_r  <= found_idx_nxt;
    found_cls_r  <= found_cls_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    count_r      <= count_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.live_count = out_count_r;

  // a new registration only ever lands in a slot that was free
  `KSTT_ASSERT(a_reg_free_slot, (mem_we |-> !valid_r[free_idx_r]), "register hit a live slot")
  // a clear empties the table on the next cycle
  `KSTT_ASSERT(a_clear_empties, (clear_fire |=> (valid_r == '0)), "clear left live slots")
  // no compare is in flight while a new request can be taken
  `KSTT_ASSERT_NEVER(a_idle_no_pend, (in_ch.ready && pend_r), "scan still active while ready")

endmodule

>>> test/keyed_slot_tracker_table_tb.sv
// Self-checking testbench for the keyed slot tracker table.
module keyed_slot_tracker_table_tb;

  // Geometry of the instance under test.
  localparam int TB_SLOTS    = 32;
  localparam int TB_KINDS    = 4;
  // Key pool is larger than the table, so register-heavy phases hit full.
  localparam int POOL_N      = 48;
  // Accept-to-result latency of the top level, used to size the final drain wait.
  localparam int LATENCY     = TB_SLOTS + 2;
  // Long receiver stall used to back the block up into its input.
  localparam int HOLD_LEN    = 300;
  // The slowest clean run is roughly 1450 items, each with the largest gaps
  // on both sides, plus the stall; this limit is several times that.
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [kstt_pkg::STATUS_W-1:0] status;
    logic [kstt_pkg::COUNT_W-1:0]  live_count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  kstt_in_if  in_ch ();
  kstt_out_if out_ch ();

  keyed_slot_tracker_table #(
    .SLOTS      (TB_SLOTS),
    .KIND_COUNT (TB_KINDS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the table, updated as each request item is accepted.
  bit                          trk_live [TB_SLOTS];
  logic [kstt_pkg::KEY_W-1:0]  trk_key  [TB_SLOTS];
  logic [kstt_pkg::KIND_W-1:0] trk_kind [TB_SLOTS];
  logic                        trk_head [TB_SLOTS];

  // Outcomes of accepted requests, oldest first.
  outcome_t outcome_q [$];

  logic [kstt_pkg::KEY_W-1:0] key_pool [POOL_N];

  int n_sent      = 0;
  int n_checked   = 0;
  int n_bad       = 0;
  int n_cycles    = 0;
  int hold_cycles = 0;
  int stat_seen [5];
  bit snd_idle    = 1'b1;
  bit rcv_idle    = 1'b1;

  // Applies one request to the shadow table and returns the status and the
  // live count of matching entries after the operation.
  function automatic outcome_t apply_request(logic [kstt_pkg::REQ_W-1:0] req,
                                             logic [kstt_pkg::KEY_W-1:0] key,
                                             logic [kstt_pkg::KIND_W-1:0] kind,
                                             logic heading);
    outcome_t res;
    int       hit;
    int       spot;
    int       n;
    bit       kind_ok;
    kind_ok    = (int'(kind) < TB_KINDS);
    res.status = kstt_pkg::STAT_OK;
    hit        = -1;
    spot       = -1;
    n          = 0;
    // Key, kind and heading only count for live slots.
    for (int i = 0; i < TB_SLOTS; i++) begin
      if (trk_live[i] && trk_key[i] == key && hit < 0) hit = i;
      if (!trk_live[i] && spot < 0) spot = i;
    end
    case (req)
      kstt_pkg::REQ_REGISTER: begin
        // Kind is checked first, then duplicates, then free space.
        if (!kind_ok) begin
          res.status = kstt_pkg::STAT_BADKIND;
        end else if (hit >= 0) begin
          res.status = kstt_pkg::STAT_DUP;
        end else if (spot < 0) begin
          res.status = kstt_pkg::STAT_FULL;
        end else begin
          trk_live[spot] = 1'b1;
          trk_key[spot]  = key;
          trk_kind[spot] = kind;
          trk_head[spot] = heading;
        end
      end
      kstt_pkg::REQ_RESOLVE: begin
        // Resolve ignores the kind check for its status.
        if (hit < 0) res.status = kstt_pkg::STAT_NOTFOUND;
        else trk_live[hit] = 1'b0;
      end
      kstt_pkg::REQ_CLEAR: begin
        for (int i = 0; i < TB_SLOTS; i++) trk_live[i] = 1'b0;
      end
      default: begin
        if (!kind_ok) res.status = kstt_pkg::STAT_BADKIND;
      end
    endcase
    if (kind_ok) begin
      for (int i = 0; i < TB_SLOTS; i++)
        if (trk_live[i] && trk_kind[i] == kind && trk_head[i] == heading) n++;
    end
    res.live_count = (n > int'(kstt_pkg::COUNT_MAX)) ? kstt_pkg::COUNT_MAX
                                                     : n[kstt_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // Key choice: a live key when asked and one exists, else mostly the pool.
  function automatic logic [kstt_pkg::KEY_W-1:0] pick_key(bit want_live);
    int live_idx [$];
    for (int i = 0; i < TB_SLOTS; i++)
      if (trk_live[i]) live_idx.push_back(i);
    if (want_live && live_idx.size() > 0)
      return trk_key[live_idx[$urandom_range(0, live_idx.size() - 1)]];
    if ($urandom_range(0, 9) < 8)
      return key_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom();
  endfunction

  // Mostly legal kinds, with a share of the invalid upper range.
  function automatic logic [kstt_pkg::KIND_W-1:0] pick_kind();
    if ($urandom_range(0, 9) == 0)
      return kstt_pkg::KIND_W'($urandom_range(TB_KINDS, 7));
    return kstt_pkg::KIND_W'($urandom_range(0, TB_KINDS - 1));
  endfunction

  // Legal kinds only.
  function automatic logic [kstt_pkg::KIND_W-1:0] legal_kind();
    return kstt_pkg::KIND_W'($urandom_range(0, TB_KINDS - 1));
  endfunction

  function automatic logic coin();
    return ($urandom_range(0, 1) != 0);
  endfunction

  function automatic void note_mismatch(string what, int exp_val, int got_val);
    n_bad++;
    if (n_bad <= 10)
      $display("mismatch on result %0d: %s expected %0d got %0d",
               n_checked, what, exp_val, got_val);
  endfunction

  // Offers one request item and waits for it to be taken. Called at a rising
  // edge; valid stays high across back-to-back items.
  task automatic send_req(logic [kstt_pkg::REQ_W-1:0] req, logic [kstt_pkg::KEY_W-1:0] key,
                          logic [kstt_pkg::KIND_W-1:0] kind, logic heading);
    int gap;
    gap = snd_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.unit_key <= key;
    in_ch.kind     <= kind;
    in_ch.heading  <= heading;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    outcome_q.push_back(apply_request(req, key, kind, heading));
    n_sent++;
  endtask

  // Hand-picked items: empty table after reset, every request type, both
  // ends of the key range, invalid kinds on each request type, duplicates,
  // unknown keys and reuse of a key after clear.
  task automatic test_directed_cases();
    send_req(kstt_pkg::REQ_QUERY,    32'h0000_0000, 3'd0, 1'b0);
    send_req(kstt_pkg::REQ_REGISTER, 32'h0000_0000, 3'd0, 1'b0);
    send_req(kstt_pkg::REQ_REGISTER, 32'h0000_0000, 3'd2, 1'b1);
    send_req(kstt_pkg::REQ_REGISTER, 32'hFFFF_FFFF, 3'd3, 1'b1);
    send_req(kstt_pkg::REQ_REGISTER, 32'h0000_1234, 3'd4, 1'b0);
    send_req(kstt_pkg::REQ_REGISTER, 32'h0000_5678, 3'd7, 1'b1);
    send_req(kstt_pkg::REQ_QUERY,    32'h0000_0000, 3'd7, 1'b1);
    send_req(kstt_pkg::REQ_QUERY,    32'h0000_0000, 3'd3, 1'b1);
    send_req(kstt_pkg::REQ_RESOLVE,  32'hAAAA_5555, 3'd1, 1'b0);
    // Resolve with a bad kind still frees the entry; count reads zero.
    send_req(kstt_pkg::REQ_RESOLVE,  32'hFFFF_FFFF, 3'd5, 1'b0);
    send_req(kstt_pkg::REQ_RESOLVE,  32'hFFFF_FFFF, 3'd3, 1'b1);
    send_req(kstt_pkg::REQ_REGISTER, 32'h5555_5555, 3'd1, 1'b0);
    send_req(kstt_pkg::REQ_REGISTER, 32'hAAAA_AAAA, 3'd2, 1'b1);
    send_req(kstt_pkg::REQ_CLEAR,    32'h0000_0000, 3'd6, 1'b1);
    send_req(kstt_pkg::REQ_QUERY,    32'h0000_0000, 3'd1, 1'b0);
    send_req(kstt_pkg::REQ_REGISTER, 32'h0000_0000, 3'd0, 1'b0);
    send_req(kstt_pkg::REQ_CLEAR,    32'hFFFF_FFFF, 3'd0, 1'b0);
  endtask

  // Fill the table past capacity, then poke at it while full: duplicate,
  // free one slot, refill it, overflow again.
  task automatic test_table_full(int rounds);
    int n;
    for (int r = 0; r < rounds; r++) begin
      snd_idle = (r % 2 == 0);
      rcv_idle = (r % 3 != 0);
      send_req(kstt_pkg::REQ_CLEAR, $urandom(), legal_kind(), coin());
      n = TB_SLOTS + $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        send_req(kstt_pkg::REQ_REGISTER, $urandom(), legal_kind(), coin());
      send_req(kstt_pkg::REQ_REGISTER, pick_key(1'b1), legal_kind(), coin());
      send_req(kstt_pkg::REQ_RESOLVE, pick_key(1'b1), pick_kind(), coin());
      send_req(kstt_pkg::REQ_REGISTER, $urandom(), legal_kind(), coin());
      send_req(kstt_pkg::REQ_REGISTER, $urandom(), legal_kind(), coin());
      send_req(kstt_pkg::REQ_QUERY, $urandom(), pick_kind(), coin());
    end
  endtask

  // Phased random traffic: fill-heavy, drain-heavy and mixed phases, each
  // with its own idling choice so some stretches run without gaps.
  task automatic test_random_traffic(int n_items);
    int                         phase_left;
    int                         mode;
    int                         roll;
    int                         reg_cut;
    int                         res_cut;
    int                         qry_cut;
    logic [kstt_pkg::REQ_W-1:0] req;
    phase_left = 0;
    mode       = 0;
    for (int k = 0; k < n_items; k++) begin
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 80);
        snd_idle   = ($urandom_range(0, 3) != 0);
        rcv_idle   = ($urandom_range(0, 3) != 0);
      end
      phase_left--;
      case (mode)
        0:       begin reg_cut = 70; res_cut = 85; qry_cut = 98; end
        1:       begin reg_cut = 25; res_cut = 80; qry_cut = 98; end
        default: begin reg_cut = 45; res_cut = 80; qry_cut = 96; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < reg_cut)      req = kstt_pkg::REQ_REGISTER;
      else if (roll < res_cut) req = kstt_pkg::REQ_RESOLVE;
      else if (roll < qry_cut) req = kstt_pkg::REQ_QUERY;
      else                     req = kstt_pkg::REQ_CLEAR;
      // Resolves mostly aim at live keys so that most of them hit.
      send_req(req, pick_key(req == kstt_pkg::REQ_RESOLVE && $urandom_range(0, 9) < 6),
               pick_kind(), coin());
    end
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering
  // back-to-back items, so the block backs up and drops in_ch.ready.
  task automatic test_output_stall();
    snd_idle    = 1'b0;
    hold_cycles = HOLD_LEN;
    for (int k = 0; k < 24; k++)
      send_req(kstt_pkg::REQ_W'($urandom_range(0, 3)), pick_key(coin()), pick_kind(),
               coin());
    snd_idle = 1'b1;
  endtask

  // Result-side ready: random gap per item, plus the long hold on request.
  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = rcv_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Each result taken is compared field by field with the oldest outcome.
  always @(posedge clk) begin : check_results
    outcome_t due;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (outcome_q.size() == 0) begin
        note_mismatch("unexpected result, status", -1, int'(out_ch.status));
      end else begin
        due = outcome_q.pop_front();
        n_checked++;
        stat_seen[int'(due.status)]++;
        if (out_ch.status !== due.status)
          note_mismatch("status", int'(due.status), int'(out_ch.status));
        if (out_ch.live_count !== due.live_count)
          note_mismatch("live_count", int'(due.live_count), int'(out_ch.live_count));
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               outcome_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // Every block input is known from time zero.
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = kstt_pkg::REQ_QUERY;
    in_ch.unit_key = '0;
    in_ch.kind     = '0;
    in_ch.heading  = 1'b0;
    out_ch.ready   = 1'b0;
    for (int i = 0; i < 5; i++) stat_seen[i] = 0;
    for (int i = 0; i < TB_SLOTS; i++) trk_live[i] = 1'b0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_table_full(4);
    test_random_traffic(1200);
    test_output_stall();
    in_ch.valid <= 1'b0;

    // Drain, then leave room for any stray result.
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d field mismatches",
             n_sent, n_checked, n_bad);
    $display("outcomes: ok %0d, duplicate %0d, bad kind %0d, full %0d, not found %0d",
             stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3], stat_seen[4]);
    if (n_bad == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
